[rtl/mso_pkg.sv]
package mso_pkg;

   // Field and register widths fixed by the host interface.
   localparam int ACTION_W      = 2;
   localparam int ROW_FIELD_W   = 6;
   localparam int DIM_FIELD_W   = 3;
   localparam int COORD_FIELD_W = 16;
   localparam int OUT_BEST_W    = 35;
   localparam int BEST_W        = 36;
   localparam int POINTS_CFG_W  = 7;
   localparam int DIMS_CFG_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_IDX_BIT   = 2;

   // Default sizing of the design store.
   localparam int DEF_MAX_POINTS = 64;
   localparam int DEF_MAX_DIMS   = 8;
   localparam int DEF_COORD_BITS = 16;

   localparam int MIN_POINTS = 2;
   localparam int MIN_DIMS   = 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD = 2'd0,
      ACT_SWAP = 2'd1,
      ACT_READ = 2'd2
   } action_type;

   typedef enum logic {
      REG_POINTS = 1'b0,
      REG_DIMS   = 1'b1
   } reg_index_type;

   typedef enum logic {
      ASEL_FIRST  = 1'b0,
      ASEL_SECOND = 1'b1
   } addr_sel_type;

   typedef enum logic [1:0] {
      WSEL_COORD   = 2'd0,
      WSEL_RDATA_B = 2'd1,
      WSEL_SWAP_A  = 2'd2,
      WSEL_SWAP_B  = 2'd3
   } wdata_sel_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic          latch;
      logic          wr_en;
      addr_sel_type  wr_addr_sel;
      wdata_sel_type wr_data_sel;
      logic          mark_stale;
      logic          rd_req;
      logic          swap_cap;
      logic          scan_start;
      logic          best_base;
      logic          keep_if_better;
      logic          out_load;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      action_type action;
      logic       bad;
      logic       stale;
      logic       scan_done;
      logic       improved;
   } status_type;

endpackage

[rtl/mso_ifs.sv]
interface mso_req_if;
   logic                                valid;
   logic                                ready;
   logic [mso_pkg::ACTION_W-1:0]        action;
   logic [mso_pkg::ROW_FIELD_W-1:0]     row_first;
   logic [mso_pkg::ROW_FIELD_W-1:0]     row_second;
   logic [mso_pkg::DIM_FIELD_W-1:0]     dim_index;
   logic [mso_pkg::COORD_FIELD_W-1:0]   coord_value;

   modport source (
      output valid, action, row_first, row_second, dim_index, coord_value,
      input  ready
   );
   modport sink (
      input  valid, action, row_first, row_second, dim_index, coord_value,
      output ready
   );
endinterface

interface mso_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                status;
   logic                                swap_kept;
   logic [mso_pkg::OUT_BEST_W-1:0]      best_min_sq_dist;
   logic [mso_pkg::COORD_FIELD_W-1:0]   read_value;

   modport source (
      output valid, status, swap_kept, best_min_sq_dist, read_value,
      input  ready
   );
   modport sink (
      input  valid, status, swap_kept, best_min_sq_dist, read_value,
      output ready
   );
endinterface

[rtl/maximin_swap_optimizer_top.sv]
// Maximin swap optimizer for a sample design held in an on-chip store.
// Requests arrive on the req channel (valid/ready): action 0 loads one
// coordinate, action 2 reads one back, action 1 proposes swapping two rows'
// values in one column. Each request yields exactly one response on the rsp
// channel with a status, the keep flag, the best minimum pairwise squared
// distance and the read value. Rows and columns in use are set through the
// csr port, which may be written only while no request is in flight.
// Loads and reads go from idle through a check state and a load or read
// state to the finish state, which fills the output register; rejected
// requests go from the check state straight to finish. A swap proposal
// writes the two values swapped, then runs one pair scan through the
// dual-read store, one column of one pair per cycle, and keeps the swap
// only if the distance grew; a kept swap skips the undo writes. After a load
// or csr write the first proposal also rebuilds the baseline, which adds a
// second pair scan before the swap is written.
// One request is worked on at a time. A finished response waits in an output
// register, so the next request is accepted while the receiver stalls; that
// request then holds at its end until the output register is free.
// Synchronous reset returns the sequencer to idle, drops rsp valid, restores
// the csr registers to their maximum sizes, zeroes the best and marks it stale.
module maximin_swap_optimizer_top #(
   parameter int MAX_POINTS = mso_pkg::DEF_MAX_POINTS,
   parameter int MAX_DIMS   = mso_pkg::DEF_MAX_DIMS,
   parameter int COORD_BITS = mso_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   mso_req_if.sink                           req,
   mso_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mso_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mso_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mso_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int PCNT_W = ($clog2(MAX_POINTS + 1) > mso_pkg::POINTS_CFG_W) ?
                           $clog2(MAX_POINTS + 1) : mso_pkg::POINTS_CFG_W;
   localparam int DCNT_W = ($clog2(MAX_DIMS + 1) > mso_pkg::DIMS_CFG_W) ?
                           $clog2(MAX_DIMS + 1) : mso_pkg::DIMS_CFG_W;

   logic [PCNT_W-1:0]    points_in_use;
   logic [DCNT_W-1:0]    dims_in_use;
   logic                 cfg_wr;
   mso_pkg::cmd_type     cmd;
   mso_pkg::status_type  stat;

   // Configuration registers; a write also marks the stored best as stale.
   // The store itself is not cleared at reset; entries must be loaded first.
   mso_csr #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .points_in_use (points_in_use),
      .dims_in_use   (dims_in_use),
      .cfg_wr        (cfg_wr)
   );

   // Sequencer: owns the handshakes and steps the datapath through each request.
   mso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: store, pair-distance pipeline, best value and response register.
   mso_dpath #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .points_in_use        (points_in_use),
      .dims_in_use          (dims_in_use),
      .cfg_wr               (cfg_wr),
      .req_action           (req.action),
      .req_row_first        (req.row_first),
      .req_row_second       (req.row_second),
      .req_dim_index        (req.dim_index),
      .req_coord_value      (req.coord_value),
      .rsp_status           (rsp.status),
      .rsp_swap_kept        (rsp.swap_kept),
      .rsp_best_min_sq_dist (rsp.best_min_sq_dist),
      .rsp_read_value       (rsp.read_value)
   );

endmodule

[rtl/mso_csr.sv]
module mso_csr #(
   parameter int MAX_POINTS = mso_pkg::DEF_MAX_POINTS,
   parameter int MAX_DIMS   = mso_pkg::DEF_MAX_DIMS,
   localparam int PCNT_W = ($clog2(MAX_POINTS + 1) > mso_pkg::POINTS_CFG_W) ?
                           $clog2(MAX_POINTS + 1) : mso_pkg::POINTS_CFG_W,
   localparam int DCNT_W = ($clog2(MAX_DIMS + 1) > mso_pkg::DIMS_CFG_W) ?
                           $clog2(MAX_DIMS + 1) : mso_pkg::DIMS_CFG_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mso_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mso_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mso_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [PCNT_W-1:0]                 points_in_use,
   output logic [DCNT_W-1:0]                 dims_in_use,
   output logic                              cfg_wr
);

   logic [PCNT_W-1:0]                    points_ff;
   logic [DCNT_W-1:0]                    dims_ff;
   logic [PCNT_W-1:0]                    points_in;
   logic [DCNT_W-1:0]                    dims_in;
   logic [mso_pkg::POINTS_CFG_W-1:0]     points_raw;
   logic [mso_pkg::DIMS_CFG_W-1:0]       dims_raw;
   mso_pkg::reg_index_type               reg_idx;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = mso_pkg::reg_index_type'(csr_paddr[mso_pkg::CSR_IDX_BIT]);

   // Written values are clamped into the legal range of each register.
   assign points_raw = csr_pwdata[mso_pkg::POINTS_CFG_W-1:0];
   assign dims_raw   = csr_pwdata[mso_pkg::DIMS_CFG_W-1:0];

   always_comb begin
      if (points_raw < mso_pkg::POINTS_CFG_W'(mso_pkg::MIN_POINTS)) begin
         points_in = PCNT_W'(mso_pkg::MIN_POINTS);
      end else if (PCNT_W'(points_raw) > PCNT_W'(MAX_POINTS)) begin
         points_in = PCNT_W'(MAX_POINTS);
      end else begin
         points_in = PCNT_W'(points_raw);
      end
      if (dims_raw < mso_pkg::DIMS_CFG_W'(mso_pkg::MIN_DIMS)) begin
         dims_in = DCNT_W'(mso_pkg::MIN_DIMS);
      end else if (DCNT_W'(dims_raw) > DCNT_W'(MAX_DIMS)) begin
         dims_in = DCNT_W'(MAX_DIMS);
      end else begin
         dims_in = DCNT_W'(dims_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= PCNT_W'(MAX_POINTS);
         dims_ff   <= DCNT_W'(MAX_DIMS);
      end else if (cfg_wr) begin
         case (reg_idx)
            mso_pkg::REG_POINTS: points_ff <= points_in;
            mso_pkg::REG_DIMS:   dims_ff   <= dims_in;
            default: begin
               points_ff <= points_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mso_pkg::REG_POINTS: csr_prdata = mso_pkg::CSR_DATA_W'(points_ff);
         mso_pkg::REG_DIMS:   csr_prdata = mso_pkg::CSR_DATA_W'(dims_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign points_in_use = points_ff;
   assign dims_in_use   = dims_ff;

endmodule

[rtl/mso_ctrl.sv]
module mso_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mso_pkg::status_type  stat,
   output mso_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_LOAD,
      S_READ,
      S_BASE_START,
      S_BASE_WAIT,
      S_BASE_SET,
      S_SWAP_RD,
      S_SWAP_W1,
      S_SWAP_W2,
      S_CAND_START,
      S_CAND_WAIT,
      S_DECIDE,
      S_UNDO1,
      S_UNDO2,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.wr_addr_sel = mso_pkg::ASEL_FIRST;
      cmd.wr_data_sel = mso_pkg::WSEL_COORD;
      case (state_ff)
         S_IDLE: begin
            cmd.latch = req_valid;
         end
         S_LOAD: begin
            cmd.wr_en      = 1'b1;
            cmd.mark_stale = 1'b1;
         end
         S_READ, S_SWAP_RD: begin
            cmd.rd_req = 1'b1;
         end
         S_BASE_START, S_CAND_START: begin
            cmd.scan_start = 1'b1;
         end
         S_BASE_SET: begin
            cmd.best_base = 1'b1;
         end
         S_SWAP_W1: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_data_sel = mso_pkg::WSEL_RDATA_B;
            cmd.swap_cap    = 1'b1;
         end
         S_SWAP_W2: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = mso_pkg::ASEL_SECOND;
            cmd.wr_data_sel = mso_pkg::WSEL_SWAP_A;
         end
         S_DECIDE: begin
            cmd.keep_if_better = 1'b1;
         end
         S_UNDO1: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_data_sel = mso_pkg::WSEL_SWAP_A;
         end
         S_UNDO2: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = mso_pkg::ASEL_SECOND;
            cmd.wr_data_sel = mso_pkg::WSEL_SWAP_B;
         end
         S_FINISH: begin
            cmd.out_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            cmd.latch = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (stat.bad) begin
                  state_ff <= S_FINISH;
               end else begin
                  case (stat.action)
                     mso_pkg::ACT_LOAD: state_ff <= S_LOAD;
                     mso_pkg::ACT_READ: state_ff <= S_READ;
                     mso_pkg::ACT_SWAP: state_ff <= stat.stale ? S_BASE_START : S_SWAP_RD;
                     default:           state_ff <= S_FINISH;
                  endcase
               end
            end
            S_LOAD:       state_ff <= S_FINISH;
            S_READ:       state_ff <= S_FINISH;
            S_BASE_START: state_ff <= S_BASE_WAIT;
            S_BASE_WAIT: begin
               if (stat.scan_done) begin
                  state_ff <= S_BASE_SET;
               end
            end
            S_BASE_SET:   state_ff <= S_SWAP_RD;
            S_SWAP_RD:    state_ff <= S_SWAP_W1;
            S_SWAP_W1:    state_ff <= S_SWAP_W2;
            S_SWAP_W2:    state_ff <= S_CAND_START;
            S_CAND_START: state_ff <= S_CAND_WAIT;
            S_CAND_WAIT: begin
               if (stat.scan_done) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE:     state_ff <= stat.improved ? S_FINISH : S_UNDO1;
            S_UNDO1:      state_ff <= S_UNDO2;
            S_UNDO2:      state_ff <= S_FINISH;
            S_FINISH: begin
               if (cmd.out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default:      state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/mso_dpath.sv]
module mso_dpath #(
   parameter int MAX_POINTS = mso_pkg::DEF_MAX_POINTS,
   parameter int MAX_DIMS   = mso_pkg::DEF_MAX_DIMS,
   parameter int COORD_BITS = mso_pkg::DEF_COORD_BITS,
   localparam int PCNT_W = ($clog2(MAX_POINTS + 1) > mso_pkg::POINTS_CFG_W) ?
                           $clog2(MAX_POINTS + 1) : mso_pkg::POINTS_CFG_W,
   localparam int DCNT_W = ($clog2(MAX_DIMS + 1) > mso_pkg::DIMS_CFG_W) ?
                           $clog2(MAX_DIMS + 1) : mso_pkg::DIMS_CFG_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mso_pkg::cmd_type                     cmd,
   output mso_pkg::status_type                  stat,
   input  logic [PCNT_W-1:0]                    points_in_use,
   input  logic [DCNT_W-1:0]                    dims_in_use,
   input  logic                                 cfg_wr,
   input  logic [mso_pkg::ACTION_W-1:0]         req_action,
   input  logic [mso_pkg::ROW_FIELD_W-1:0]      req_row_first,
   input  logic [mso_pkg::ROW_FIELD_W-1:0]      req_row_second,
   input  logic [mso_pkg::DIM_FIELD_W-1:0]      req_dim_index,
   input  logic [mso_pkg::COORD_FIELD_W-1:0]    req_coord_value,
   output logic                                 rsp_status,
   output logic                                 rsp_swap_kept,
   output logic [mso_pkg::OUT_BEST_W-1:0]       rsp_best_min_sq_dist,
   output logic [mso_pkg::COORD_FIELD_W-1:0]    rsp_read_value
);

   localparam int DEPTH     = MAX_POINTS * MAX_DIMS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int ROW_W     = $clog2(MAX_POINTS);
   localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int SQ_W      = 2 * COORD_BITS;
   localparam int SUM_W     = SQ_W + $clog2(MAX_DIMS + 1);
   localparam int MIN_EXT_W = (SUM_W > mso_pkg::BEST_W) ? SUM_W : mso_pkg::BEST_W;
   localparam int CEXT_W    = (COORD_BITS > mso_pkg::COORD_FIELD_W) ?
                              COORD_BITS : mso_pkg::COORD_FIELD_W;

   typedef struct packed {
      logic valid;
      logic last_dim;
      logic last_pair;
   } tag_type;

   // Latched request.
   logic [mso_pkg::ACTION_W-1:0]       act_ff;
   logic [mso_pkg::ROW_FIELD_W-1:0]    row1_ff;
   logic [mso_pkg::ROW_FIELD_W-1:0]    row2_ff;
   logic [mso_pkg::DIM_FIELD_W-1:0]    dim_ff;
   logic [mso_pkg::COORD_FIELD_W-1:0]  coord_ff;

   // Design store and its read registers.
   logic [COORD_BITS-1:0]  store_mem [DEPTH];
   logic [COORD_BITS-1:0]  rdata_a_ff;
   logic [COORD_BITS-1:0]  rdata_b_ff;
   logic [COORD_BITS-1:0]  swap_a_ff;
   logic [COORD_BITS-1:0]  swap_b_ff;
   logic [ADDR_W-1:0]      addr_first;
   logic [ADDR_W-1:0]      addr_second;
   logic [ADDR_W-1:0]      scan_addr_a;
   logic [ADDR_W-1:0]      scan_addr_b;
   logic [ADDR_W-1:0]      rd_addr_a;
   logic [ADDR_W-1:0]      rd_addr_b;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COORD_BITS-1:0]  wr_data;
   logic                   rd_en;
   logic [CEXT_W-1:0]      coord_ext;
   logic [CEXT_W-1:0]      rdata_ext;

   // Pair scan.
   logic                   issuing_ff;
   logic [ROW_W-1:0]       a_ff;
   logic [ROW_W-1:0]       b_ff;
   logic [DIM_W-1:0]       d_ff;
   logic                   last_dim;
   logic                   b_last;
   logic                   a_last;
   tag_type                t1_in;
   tag_type                t1_ff;
   tag_type                t2_ff;
   tag_type                t3_ff;
   logic [COORD_BITS-1:0]  diff_ff;
   logic [SQ_W-1:0]        sq_ff;
   logic [SUM_W-1:0]       acc_ff;
   logic [SUM_W-1:0]       psum_ff;
   logic                   psum_valid_ff;
   logic                   psum_last_ff;
   logic [SUM_W-1:0]       min_ff;
   logic                   first_ff;
   logic                   done_ff;
   logic [MIN_EXT_W-1:0]   min_ext;
   logic [mso_pkg::BEST_W-1:0] cand;

   // Best value and flags.
   logic [mso_pkg::BEST_W-1:0] best_ff;
   logic                   stale_ff;
   logic                   kept_ff;
   logic                   improved;

   // Range checks.
   logic                   row1_bad;
   logic                   row2_bad;
   logic                   dim_bad;
   logic                   bad;
   mso_pkg::action_type    act;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff   <= req_action;
         row1_ff  <= req_row_first;
         row2_ff  <= req_row_second;
         dim_ff   <= req_dim_index;
         coord_ff <= req_coord_value;
      end
   end

   assign act      = mso_pkg::action_type'(act_ff);
   assign row1_bad = PCNT_W'(row1_ff) >= points_in_use;
   assign row2_bad = PCNT_W'(row2_ff) >= points_in_use;
   assign dim_bad  = DCNT_W'(dim_ff) >= dims_in_use;

   always_comb begin
      case (act)
         mso_pkg::ACT_LOAD, mso_pkg::ACT_READ: bad = row1_bad || dim_bad;
         mso_pkg::ACT_SWAP: bad = row1_bad || row2_bad || dim_bad || (row1_ff == row2_ff);
         default:           bad = 1'b1;
      endcase
   end

   // Row-major layout: entry of row r, column d sits at r * MAX_DIMS + d.
   assign addr_first  = ADDR_W'(row1_ff) * ADDR_W'(MAX_DIMS) + ADDR_W'(dim_ff);
   assign addr_second = ADDR_W'(row2_ff) * ADDR_W'(MAX_DIMS) + ADDR_W'(dim_ff);
   assign scan_addr_a = ADDR_W'(a_ff) * ADDR_W'(MAX_DIMS) + ADDR_W'(d_ff);
   assign scan_addr_b = ADDR_W'(b_ff) * ADDR_W'(MAX_DIMS) + ADDR_W'(d_ff);

   assign rd_en     = cmd.rd_req || issuing_ff;
   assign rd_addr_a = issuing_ff ? scan_addr_a : addr_first;
   assign rd_addr_b = issuing_ff ? scan_addr_b : addr_second;
   assign wr_addr   = (cmd.wr_addr_sel == mso_pkg::ASEL_SECOND) ? addr_second : addr_first;
   assign coord_ext = CEXT_W'(coord_ff);

   always_comb begin
      case (cmd.wr_data_sel)
         mso_pkg::WSEL_COORD:   wr_data = coord_ext[COORD_BITS-1:0];
         mso_pkg::WSEL_RDATA_B: wr_data = rdata_b_ff;
         mso_pkg::WSEL_SWAP_A:  wr_data = swap_a_ff;
         mso_pkg::WSEL_SWAP_B:  wr_data = swap_b_ff;
         default:               wr_data = swap_a_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_a_ff <= store_mem[rd_addr_a];
         rdata_b_ff <= store_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.swap_cap) begin
         swap_a_ff <= rdata_a_ff;
         swap_b_ff <= rdata_b_ff;
      end
   end

   // Pair walk: a < b over the rows in use, all columns of a pair in turn.
   assign last_dim = DCNT_W'(d_ff) == dims_in_use - DCNT_W'(1);
   assign b_last   = PCNT_W'(b_ff) == points_in_use - PCNT_W'(1);
   assign a_last   = PCNT_W'(a_ff) == points_in_use - PCNT_W'(2);
   assign t1_in    = '{valid: issuing_ff, last_dim: last_dim,
                       last_pair: last_dim && b_last && a_last};

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         a_ff       <= '0;
         b_ff       <= '0;
         d_ff       <= '0;
      end else if (cmd.scan_start) begin
         issuing_ff <= 1'b1;
         a_ff       <= '0;
         b_ff       <= ROW_W'(1);
         d_ff       <= '0;
      end else if (issuing_ff) begin
         if (last_dim) begin
            d_ff <= '0;
            if (t1_in.last_pair) begin
               issuing_ff <= 1'b0;
            end else if (b_last) begin
               a_ff <= a_ff + ROW_W'(1);
               b_ff <= a_ff + ROW_W'(2);
            end else begin
               b_ff <= b_ff + ROW_W'(1);
            end
         end else begin
            d_ff <= d_ff + DIM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
      end else begin
         t1_ff <= t1_in;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= (rdata_a_ff > rdata_b_ff) ? (rdata_a_ff - rdata_b_ff) :
                                             (rdata_b_ff - rdata_a_ff);
      sq_ff   <= SQ_W'(diff_ff) * SQ_W'(diff_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         psum_valid_ff <= 1'b0;
         psum_last_ff  <= 1'b0;
         first_ff      <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         psum_valid_ff <= t3_ff.valid && t3_ff.last_dim;
         psum_last_ff  <= t3_ff.last_pair;
         done_ff       <= psum_valid_ff && psum_last_ff;
         if (t3_ff.valid) begin
            if (t3_ff.last_dim) begin
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_ff + SUM_W'(sq_ff);
            end
         end
         if (cmd.scan_start) begin
            first_ff <= 1'b1;
         end else if (psum_valid_ff) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      psum_ff <= acc_ff + SUM_W'(sq_ff);
      if (psum_valid_ff && (first_ff || (psum_ff < min_ff))) begin
         min_ff <= psum_ff;
      end
   end

   assign min_ext  = MIN_EXT_W'(min_ff);
   assign cand     = min_ext[mso_pkg::BEST_W-1:0];
   assign improved = cand > best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '0;
         stale_ff <= 1'b1;
      end else begin
         if (cmd.best_base) begin
            best_ff  <= cand;
            stale_ff <= 1'b0;
         end else if (cmd.keep_if_better && improved) begin
            best_ff <= cand;
         end
         if (cfg_wr || cmd.mark_stale) begin
            stale_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kept_ff <= 1'b0;
      end else if (cmd.keep_if_better && improved) begin
         kept_ff <= 1'b1;
      end
   end

   assign rdata_ext = CEXT_W'(rdata_a_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status           <= bad;
         rsp_swap_kept        <= kept_ff;
         rsp_best_min_sq_dist <= best_ff[mso_pkg::OUT_BEST_W-1:0];
         rsp_read_value       <= (act == mso_pkg::ACT_READ && !bad) ?
                                 rdata_ext[mso_pkg::COORD_FIELD_W-1:0] : '0;
      end
   end

   assign stat = '{action: act, bad: bad, stale: stale_ff,
                   scan_done: done_ff, improved: improved};

`ifndef SYNTHESIS
   // The store is never written while a scan is reading it.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !issuing_ff)
      else $error("store write during a pair scan");

   // A scan reports completion only after its last pair was issued.
   a_done_after_issue: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !issuing_ff && !t1_ff.valid && !t2_ff.valid && !t3_ff.valid)
      else $error("scan done while pairs still in flight");

   // The kept decision never lowers the best value.
   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      cmd.keep_if_better |=> best_ff >= $past(best_ff))
      else $error("best value decreased on a swap decision");

   // Setting the baseline clears the stale mark unless a load or write races it.
   a_base_clears_stale: assert property (@(posedge clock) disable iff (reset)
      cmd.best_base && !cfg_wr && !cmd.mark_stale |=> !stale_ff)
      else $error("baseline did not clear the stale mark");
`endif

endmodule

[dv/maximin_check_pkg.sv]
package maximin_check_pkg;
   import mso_pkg::*;

   localparam int STORE_DEPTH = DEF_MAX_POINTS * DEF_MAX_DIMS;

   // Action encoding that the block does not define; it must be rejected.
   localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic [ROW_FIELD_W-1:0]   row_first;
      logic [ROW_FIELD_W-1:0]   row_second;
      logic [DIM_FIELD_W-1:0]   dim_index;
      logic [COORD_FIELD_W-1:0] coord_value;
   } mso_request_t;

   typedef struct packed {
      logic                     status;
      logic                     swap_kept;
      logic [OUT_BEST_W-1:0]    best_min_sq_dist;
      logic [COORD_FIELD_W-1:0] read_value;
   } mso_response_t;

   // Mirrors the design store, the best distance and the size registers, and
   // queues the response that each accepted request must produce.
   class maximin_tracker;
      logic [COORD_FIELD_W-1:0] coords [STORE_DEPTH];
      bit [BEST_W-1:0]          best_sq;
      bit                       best_stale;
      int unsigned              points;
      int unsigned              dims;
      mso_response_t            pending_results [$];
      int unsigned              error_count;

      function new();
         foreach (coords[i]) coords[i] = '0;
         best_sq     = '0;
         best_stale  = 1'b1;
         points      = DEF_MAX_POINTS;
         dims        = DEF_MAX_DIMS;
         error_count = 0;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // Written values are masked to the register width, then clamped.
      function void write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         int unsigned v;
         if (idx == REG_POINTS) begin
            v = int'(value[POINTS_CFG_W-1:0]);
            if (v < MIN_POINTS) v = MIN_POINTS;
            if (v > DEF_MAX_POINTS) v = DEF_MAX_POINTS;
            points = v;
         end else begin
            v = int'(value[DIMS_CFG_W-1:0]);
            if (v < MIN_DIMS) v = MIN_DIMS;
            if (v > DEF_MAX_DIMS) v = DEF_MAX_DIMS;
            dims = v;
         end
         best_stale = 1'b1;
      endfunction

      function bit [BEST_W-1:0] min_pair_sq_dist();
         bit [63:0] least;
         bit [63:0] sum;
         bit [63:0] x;
         bit [63:0] y;
         least = '1;
         for (int a = 0; a < points; a++) begin
            for (int b = a + 1; b < points; b++) begin
               sum = '0;
               for (int d = 0; d < dims; d++) begin
                  x = 64'(coords[a * DEF_MAX_DIMS + d]);
                  y = 64'(coords[b * DEF_MAX_DIMS + d]);
                  sum += (x > y) ? (x - y) * (x - y) : (y - x) * (y - x);
               end
               if (sum < least) least = sum;
            end
         end
         return least[BEST_W-1:0];
      endfunction

      function void exchange(int unsigned first, int unsigned second, int unsigned dim);
         logic [COORD_FIELD_W-1:0] held;
         held = coords[first * DEF_MAX_DIMS + dim];
         coords[first * DEF_MAX_DIMS + dim] = coords[second * DEF_MAX_DIMS + dim];
         coords[second * DEF_MAX_DIMS + dim] = held;
      endfunction

      function void note_request(mso_request_t item);
         mso_response_t result;
         int unsigned   first;
         int unsigned   second;
         int unsigned   dim;
         bit            in_range;
         bit [BEST_W-1:0] candidate;
         result   = '0;
         first    = item.row_first;
         second   = item.row_second;
         dim      = item.dim_index;
         in_range = (first < points) && (dim < dims);
         result.status = STATUS_DONE;
         case (item.action)
            ACT_LOAD: begin
               if (!in_range) begin
                  result.status = STATUS_REJECTED;
               end else begin
                  coords[first * DEF_MAX_DIMS + dim] = item.coord_value;
                  best_stale = 1'b1;
               end
            end
            ACT_SWAP: begin
               if (!in_range || second >= points || first == second) begin
                  result.status = STATUS_REJECTED;
               end else begin
                  if (best_stale) begin
                     best_sq    = min_pair_sq_dist();
                     best_stale = 1'b0;
                  end
                  exchange(first, second, dim);
                  candidate = min_pair_sq_dist();
                  if (candidate > best_sq) begin
                     best_sq          = candidate;
                     result.swap_kept = 1'b1;
                  end else begin
                     exchange(first, second, dim);
                  end
               end
            end
            ACT_READ: begin
               if (!in_range) result.status = STATUS_REJECTED;
               else result.read_value = coords[first * DEF_MAX_DIMS + dim];
            end
            default: result.status = STATUS_REJECTED;
         endcase
         result.best_min_sq_dist = best_sq[OUT_BEST_W-1:0];
         pending_results.push_back(result);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
            error_count++;
         end
      endfunction

      function void check_response(mso_response_t got);
         mso_response_t want;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: 0x%0h", got);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("swap_kept", 64'(want.swap_kept), 64'(got.swap_kept));
         compare_field("best_min_sq_dist", 64'(want.best_min_sq_dist),
                       64'(got.best_min_sq_dist));
         compare_field("read_value", 64'(want.read_value), 64'(got.read_value));
      endfunction
   endclass

endpackage

[dv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mso_pkg::*;
   import maximin_check_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 5;
   // A long hold on the response side, well past the time the block needs to
   // fill its output register and its one working slot with short requests.
   localparam int LONG_HOLD_CYCLES = 400;
   // Cycles of quiet before a register write and after the last response.
   localparam int SETTLE_CYCLES    = 20;
   localparam int DRAIN_CYCLES     = 40;
   // Only small designs are scanned, so even with every request a swap that
   // rebuilds its baseline under the longest stalls a correct run stays far
   // below this limit.
   localparam longint RUN_LIMIT_NS = 64'd10_000_000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Idling odds in percent, set per phase by the stimulus process.
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   // Asks the response process for one long hold-off.
   logic        hold_trigger;

   maximin_tracker maximin;

   mso_req_if req_chan ();
   mso_rsp_if rsp_chan ();

   maximin_swap_optimizer_top DUT (
      .clock,
      .reset,
      .req (req_chan),
      .rsp (rsp_chan),
      .csr_psel,
      .csr_penable,
      .csr_pwrite,
      .csr_paddr,
      .csr_pwdata,
      .csr_prdata,
      .csr_pready
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic mso_request_t request_of(logic [ACTION_W-1:0] action,
                                               int unsigned first, int unsigned second,
                                               int unsigned dim, int unsigned value);
      mso_request_t item;
      item.action      = action;
      item.row_first   = ROW_FIELD_W'(first);
      item.row_second  = ROW_FIELD_W'(second);
      item.dim_index   = DIM_FIELD_W'(dim);
      item.coord_value = COORD_FIELD_W'(value);
      return item;
   endfunction

   // Most requests are well formed for the current size: swaps of two
   // distinct rows in range, loads and reads of written entries. The rest
   // is noise over the whole field range, mostly rejected at small sizes.
   function automatic mso_request_t random_request(int unsigned points, int unsigned dims,
                                                   int unsigned swap_pct);
      int unsigned pick;
      int unsigned first;
      pick  = $urandom_range(99);
      first = $urandom_range(points - 1);
      if (pick >= 85)
         return request_of(ACTION_W'($urandom_range(3)), $urandom_range(63),
                           $urandom_range(63), $urandom_range(7), $urandom_range(16'hFFFF));
      if (pick < swap_pct)
         return request_of(ACT_SWAP, first, (first + $urandom_range(points - 1, 1)) % points,
                           $urandom_range(dims - 1), $urandom_range(16'hFFFF));
      return request_of(pick[0] ? ACT_LOAD : ACT_READ, first, $urandom_range(63),
                        $urandom_range(dims - 1), $urandom_range(16'hFFFF));
   endfunction

   // Offers one request and returns in the time step of its acceptance,
   // leaving valid high so that the next request can follow without a gap.
   task automatic send_request(input mso_request_t item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.action      <= item.action;
      req_chan.row_first   <= item.row_first;
      req_chan.row_second  <= item.row_second;
      req_chan.dim_index   <= item.dim_index;
      req_chan.coord_value <= item.coord_value;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      maximin.note_request(item);
   endtask

   // One APB write: a setup cycle, then an access cycle at whose closing edge
   // the register takes the value. The select is left high so that a second
   // write can follow directly; the caller closes the transfer.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << CSR_IDX_BIT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      maximin.write_register(idx, value);
   endtask

   // Registers are written only once every response has come back and the
   // block has had time to settle into idle.
   task automatic configure_design(input logic [CSR_DATA_W-1:0] points_word,
                                   input logic [CSR_DATA_W-1:0] dims_word);
      req_chan.valid <= 1'b0;
      while (maximin.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_POINTS, points_word);
      csr_write(REG_DIMS, dims_word);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic directed_checks();
      // At the reset size of 64 by 8 the store is still unwritten, so only
      // requests that read nothing are sent: an unknown action with every
      // field at its maximum, a load and read-back of the last entry, and a
      // swap of a row with itself.
      send_request(request_of(ACT_UNDEFINED, 63, 63, 7, 16'hFFFF));
      send_request(request_of(ACT_LOAD, 63, 0, 7, 16'hFFFF));
      send_request(request_of(ACT_READ, 63, 0, 7, 0));
      send_request(request_of(ACT_SWAP, 63, 63, 7, 0));

      // Out-of-range register values saturate: the points field reads as
      // zero and clamps up to two, the dims field reads as zero and clamps
      // up to one. This is the smallest design the block supports.
      configure_design(32'hFFFF_FF80, 32'hFFFF_FFF0);
      send_request(request_of(ACT_LOAD, 0, 0, 0, 16'h0000));
      send_request(request_of(ACT_LOAD, 1, 0, 0, 16'hFFFF));
      // Each index past its range is rejected without effect.
      send_request(request_of(ACT_LOAD, 2, 0, 0, 16'h1234));
      send_request(request_of(ACT_READ, 0, 0, 1, 0));
      send_request(request_of(ACT_SWAP, 0, 2, 0, 0));
      send_request(request_of(ACT_SWAP, 2, 0, 0, 0));
      send_request(request_of(ACT_READ, 63, 0, 0, 0));
      // The first proposal rebuilds the baseline; with two rows a swap
      // cannot change the distance, so it is undone.
      send_request(request_of(ACT_SWAP, 0, 1, 0, 0));
      send_request(request_of(ACT_READ, 1, 0, 0, 0));
      // After a load the best is stale but still shown unchanged until the
      // next proposal refreshes it.
      send_request(request_of(ACT_LOAD, 0, 0, 0, 16'h8000));
      send_request(request_of(ACT_READ, 0, 0, 0, 0));
      send_request(request_of(ACT_SWAP, 1, 0, 0, 0));

      // Three rows on a diagonal with the middle one close to the first:
      // swapping the second column of the outer rows spreads them apart and
      // is kept, and swapping it back is worse and is undone. The written
      // words carry bits above each register's width.
      configure_design(32'h0000_0083, 32'h0000_0012);
      send_request(request_of(ACT_LOAD, 0, 0, 0, 16'h0000));
      send_request(request_of(ACT_LOAD, 0, 0, 1, 16'h0000));
      send_request(request_of(ACT_LOAD, 1, 0, 0, 16'h1000));
      send_request(request_of(ACT_LOAD, 1, 0, 1, 16'h1000));
      send_request(request_of(ACT_LOAD, 2, 0, 0, 16'h8000));
      send_request(request_of(ACT_LOAD, 2, 0, 1, 16'h8000));
      send_request(request_of(ACT_SWAP, 0, 2, 1, 0));
      send_request(request_of(ACT_SWAP, 2, 0, 1, 0));
   endtask

   // A phase sets the size, loads every entry in use so that no scan ever
   // touches an unwritten entry, and then sends random requests.
   task automatic run_phase(input int unsigned points_word, input int unsigned dims_word,
                            input int unsigned sender_pct, input int unsigned receiver_pct,
                            input int unsigned item_count, input int unsigned swap_pct,
                            input bit hold_receiver);
      configure_design(points_word | ($urandom() << POINTS_CFG_W),
                       dims_word | ($urandom() << DIMS_CFG_W));
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
      for (int r = 0; r < maximin.points; r++)
         for (int d = 0; d < maximin.dims; d++)
            send_request(request_of(ACT_LOAD, r, $urandom_range(63), d,
                                    $urandom_range(16'hFFFF)));
      // The hold-off starts while the sender keeps offering requests, so the
      // block fills up and has to stall its request side.
      if (hold_receiver) hold_trigger <= 1'b1;
      repeat (item_count)
         send_request(random_request(maximin.points, maximin.dims, swap_pct));
   endtask

   // Response side: checks every accepted response and drives ready for the
   // next cycle, either from the phase's stall odds or from a long hold-off
   // that this process counts down itself.
   initial begin : response_sink
      int unsigned   hold_left;
      mso_response_t got;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got = {rsp_chan.status, rsp_chan.swap_kept, rsp_chan.best_min_sq_dist,
                   rsp_chan.read_value};
            maximin.check_response(got);
         end
         if (hold_trigger === 1'b1) begin
            hold_trigger <= 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin : stimulus
      maximin              = new();
      reset                = 1'b1;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      req_chan.valid       = 1'b0;
      req_chan.action      = '0;
      req_chan.row_first   = '0;
      req_chan.row_second  = '0;
      req_chan.dim_index   = '0;
      req_chan.coord_value = '0;
      sender_idle_pct      = 0;
      receiver_stall_pct   = 0;
      hold_trigger         = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      directed_checks();

      // Small designs keep swap proposals short. The phases walk through the
      // idling patterns: none (with the long hold-off), a sender idle most
      // of the time, a receiver stalling most of the time, and both sides
      // idling now and then. The full column count is reached by writing a
      // value above its range; the full row count is the reset size that
      // the first directed requests use.
      run_phase(4, 2, 0, 0, 12, 45, 1'b1);
      run_phase(2, 15, 87, 0, 8, 45, 1'b0);
      run_phase(3, 2, 0, 87, 10, 45, 1'b0);
      run_phase($urandom_range(4, 2), $urandom_range(3, 1), 12, 12, 10, 45, 1'b0);

      req_chan.valid <= 1'b0;
      receiver_stall_pct = 0;
      while (maximin.pending() != 0) @(posedge clock);
      // Any response beyond the last expected one would show up here.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (maximin.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
